@@ hw/rtl/ecd_pkg.sv @@
package ecd_pkg;

    // default sizes
    localparam int DEF_MAX_CARS  = 16;
    localparam int DEF_MAX_STOPS = 64;

    // request kinds
    localparam logic [1:0] KIND_REG    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CALL   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // door codes that allow a dispatch
    localparam logic [2:0] DOOR_OPENING = 3'd0;
    localparam logic [2:0] DOOR_CLOSED  = 3'd3;

    // answer codes
    localparam logic [2:0] ANS_ASSIGNED = 3'd0;
    localparam logic [2:0] ANS_UNAVAIL  = 3'd1;
    localparam logic [2:0] ANS_DISPATCH = 3'd2;
    localparam logic [2:0] ANS_REJECT   = 3'd3;
    localparam logic [2:0] ANS_QFULL    = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       car_rd;
        logic       car_rd_last;
        logic       car_wr_new;
        logic       car_wr_move;
        logic       hit_save;
        logic       q_rd;
        logic       q_wr_src;
        logic       q_wr_dst;
        logic       q_wr_back;
        logic       stop_save;
        logic       stop_pop;
        logic       emit;
        logic [2:0] answer;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] kind;
        logic       cars_full;
        logic       end_cars;
        logic       end_stops;
        logic       id_match;
        logic       covers;
        logic       q_full;
        logic       q_match;
        logic       ready;
    } t_sts;

endpackage

@@ hw/rtl/ecd_ctrl.sv @@
module ecd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ecd_pkg::t_sts  i_sts,
    output ecd_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CAR_RD, S_CAR_CHK, S_REM_WR, S_CALL_DEC, S_CALL_DST,
        S_Q_RD, S_Q_CHK, S_SH_RD, S_SH_WR
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.kind == ecd_pkg::KIND_REG && i_sts.cars_full) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.answer = ecd_pkg::ANS_REJECT;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CAR_RD;
                end
            end
            S_CAR_RD: begin
                if (i_sts.end_cars) begin
                    n_state = S_IDLE;
                    if (i_sts.kind == ecd_pkg::KIND_REG) begin
                        o_cmd.car_wr_new = 1'b1;
                    end else if (i_sts.kind == ecd_pkg::KIND_CALL) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.answer = ecd_pkg::ANS_UNAVAIL;
                    end
                end else begin
                    o_cmd.car_rd = 1'b1;
                    n_state      = S_CAR_CHK;
                end
            end
            S_CAR_CHK: begin
                o_cmd.idx_inc = 1'b1;
                n_state       = S_CAR_RD;
                unique case (i_sts.kind)
                    ecd_pkg::KIND_REG: begin
                        if (i_sts.id_match) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.answer = ecd_pkg::ANS_REJECT;
                            n_state      = S_IDLE;
                        end
                    end
                    ecd_pkg::KIND_REMOVE: begin
                        if (i_sts.id_match) begin
                            o_cmd.hit_save    = 1'b1;
                            o_cmd.car_rd_last = 1'b1;
                            n_state           = S_REM_WR;
                        end
                    end
                    ecd_pkg::KIND_CALL: begin
                        if (i_sts.covers) begin
                            o_cmd.hit_save = 1'b1;
                            n_state        = S_CALL_DEC;
                        end
                    end
                    default: begin
                        if (i_sts.id_match) begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.idx_inc = 1'b0;
                            n_state       = i_sts.ready ? S_Q_RD : S_IDLE;
                        end
                    end
                endcase
            end
            S_REM_WR: begin
                o_cmd.car_wr_move = 1'b1;
                n_state           = S_IDLE;
            end
            S_CALL_DEC: begin
                if (i_sts.q_full) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.answer = ecd_pkg::ANS_QFULL;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.q_wr_src = 1'b1;
                    n_state        = S_CALL_DST;
                end
            end
            S_CALL_DST: begin
                o_cmd.q_wr_dst = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.answer   = ecd_pkg::ANS_ASSIGNED;
                n_state        = S_IDLE;
            end
            S_Q_RD: begin
                if (i_sts.end_stops) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_Q_CHK;
                end
            end
            S_Q_CHK: begin
                o_cmd.idx_inc = 1'b1;
                if (i_sts.q_match) begin
                    o_cmd.stop_save = 1'b1;
                    n_state         = S_SH_RD;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.end_stops) begin
                    o_cmd.stop_pop = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.answer   = ecd_pkg::ANS_DISPATCH;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.q_wr_back = 1'b1;
                o_cmd.idx_inc   = 1'b1;
                n_state         = S_SH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // every result ends the request
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("result not followed by idle");

    // destination stop follows source stop
    a_src_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.q_wr_src |=> o_cmd.q_wr_dst)
        else $error("source stop without destination stop");

    // accepted word goes to decode
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

endmodule

@@ hw/rtl/ecd_dpath.sv @@
module ecd_dpath #(
    parameter int MAX_CARS  = ecd_pkg::DEF_MAX_CARS,
    parameter int MAX_STOPS = ecd_pkg::DEF_MAX_STOPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecd_pkg::t_cmd     i_cmd,
    output ecd_pkg::t_sts     o_sts,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_car_id,
    input  logic signed [7:0] i_lowest_floor,
    input  logic signed [7:0] i_highest_floor,
    input  logic signed [7:0] i_source_floor,
    input  logic signed [7:0] i_target_floor,
    input  logic [2:0]        i_door_state,
    input  logic signed [7:0] i_now_floor,
    input  logic signed [7:0] i_heading_floor,
    output logic              o_strobe,
    output logic [2:0]        o_answer,
    output logic [7:0]        o_chosen_car,
    output logic signed [7:0] o_stop_floor
);

    localparam int CA_W = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CC_W = $clog2(MAX_CARS + 1);
    localparam int QA_W = $clog2(MAX_STOPS);
    localparam int QC_W = $clog2(MAX_STOPS + 1);
    localparam int QX_W = QC_W + 1;
    localparam int IW   = (CC_W > QC_W) ? CC_W : QC_W;

    // car entry: id, lowest, highest
    logic [23:0] r_car_mem [MAX_CARS];
    logic [15:0] r_q_mem [MAX_STOPS];
    logic [23:0] r_car_rd;
    logic [15:0] r_q_rd;

    logic [CC_W-1:0] r_car_cnt;
    logic [QC_W-1:0] r_stop_cnt;
    logic [IW-1:0]   r_idx;
    logic [CA_W-1:0] r_hit;
    logic [7:0]      r_hit_id;
    logic [7:0]      r_stop_floor;

    logic [1:0]        r_kind;
    logic [7:0]        r_id;
    logic signed [7:0] r_lo, r_hi, r_src, r_dst, r_now, r_head;
    logic [2:0]        r_door;

    logic signed [7:0] rd_lo, rd_hi, span_lo, span_hi;
    logic [CC_W-1:0]   last_car;
    logic [QC_W-1:0]   stop_next;
    logic [IW-1:0]     idx_prev;

    assign rd_lo     = r_car_rd[15:8];
    assign rd_hi     = r_car_rd[7:0];
    assign span_lo   = (rd_hi < rd_lo) ? rd_hi : rd_lo;
    assign span_hi   = (rd_hi < rd_lo) ? rd_lo : rd_hi;
    assign last_car  = r_car_cnt - CC_W'(1);
    assign stop_next = r_stop_cnt + QC_W'(1);
    assign idx_prev  = r_idx - IW'(1);

    // status to controller
    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.cars_full = (r_car_cnt == CC_W'(MAX_CARS));
        o_sts.end_cars  = (r_idx == IW'(r_car_cnt));
        o_sts.end_stops = (r_idx == IW'(r_stop_cnt));
        o_sts.id_match  = (r_car_rd[23:16] == r_id);
        o_sts.covers    = (r_src >= span_lo) && (r_src <= span_hi) &&
                          (r_dst >= span_lo) && (r_dst <= span_hi);
        o_sts.q_full    = (QX_W'(r_stop_cnt) + QX_W'(2)) > QX_W'(MAX_STOPS);
        o_sts.q_match   = (r_q_rd[15:8] == r_id);
        o_sts.ready     = (r_door == ecd_pkg::DOOR_CLOSED) ||
                          (r_door == ecd_pkg::DOOR_OPENING) || (r_now == r_head);
    end

    // request word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_id   <= i_car_id;
            r_lo   <= i_lowest_floor;
            r_hi   <= i_highest_floor;
            r_src  <= i_source_floor;
            r_dst  <= i_target_floor;
            r_door <= i_door_state;
            r_now  <= i_now_floor;
            r_head <= i_heading_floor;
        end
    end

    // car table
    always_ff @(posedge i_clk) begin
        if (i_cmd.car_wr_new) begin
            r_car_mem[r_car_cnt[CA_W-1:0]] <= {r_id, r_lo, r_hi};
        end else if (i_cmd.car_wr_move) begin
            r_car_mem[r_hit] <= r_car_rd;
        end
        if (i_cmd.car_rd) begin
            r_car_rd <= r_car_mem[r_idx[CA_W-1:0]];
        end else if (i_cmd.car_rd_last) begin
            r_car_rd <= r_car_mem[last_car[CA_W-1:0]];
        end
    end

    // stop queue
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_wr_src) begin
            r_q_mem[r_stop_cnt[QA_W-1:0]] <= {r_hit_id, r_src};
        end else if (i_cmd.q_wr_dst) begin
            r_q_mem[stop_next[QA_W-1:0]] <= {r_hit_id, r_dst};
        end else if (i_cmd.q_wr_back) begin
            r_q_mem[idx_prev[QA_W-1:0]] <= r_q_rd;
        end
        if (i_cmd.q_rd) begin
            r_q_rd <= r_q_mem[r_idx[QA_W-1:0]];
        end
    end

    // scan index and saved hits
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.hit_save) begin
            r_hit    <= r_idx[CA_W-1:0];
            r_hit_id <= r_car_rd[23:16];
        end
        if (i_cmd.stop_save) begin
            r_stop_floor <= r_q_rd[7:0];
        end
    end

    // fill counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_cnt  <= '0;
            r_stop_cnt <= '0;
        end else begin
            if (i_cmd.car_wr_new) begin
                r_car_cnt <= r_car_cnt + CC_W'(1);
            end else if (i_cmd.car_wr_move) begin
                r_car_cnt <= last_car;
            end
            if (i_cmd.q_wr_dst) begin
                r_stop_cnt <= r_stop_cnt + QC_W'(2);
            end else if (i_cmd.stop_pop) begin
                r_stop_cnt <= r_stop_cnt - QC_W'(1);
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_answer     <= i_cmd.answer;
            o_stop_floor <= '0;
            unique case (i_cmd.answer)
                ecd_pkg::ANS_UNAVAIL: o_chosen_car <= '0;
                ecd_pkg::ANS_ASSIGNED, ecd_pkg::ANS_QFULL: o_chosen_car <= r_hit_id;
                ecd_pkg::ANS_DISPATCH: begin
                    o_chosen_car <= r_id;
                    o_stop_floor <= r_stop_floor;
                end
                default: o_chosen_car <= r_id;
            endcase
        end
    end

endmodule

@@ hw/rtl/elevator_call_dispatcher_unit.sv @@
// elevator call dispatcher
// a request word is taken at a rising edge with start high and busy low; kind
// selects register car, remove car, call or status update. busy stays high
// until the request is finished and the next word may follow the cycle after.
// a request gives at most one result word, shown on o_answer, o_chosen_car and
// o_stop_floor for exactly one cycle with o_strobe high; the receiver cannot
// stall, so the result is simply taken in that cycle.
// each car table entry visited takes a registered read, then a compare; each
// stop queue entry scanned or shifted takes a registered read, then a compare
// or a write back. register, remove and call scan the car table only; a status
// update scans the car table and then the stop queue. the single-port car and
// stop memories set this order.
// reset (synchronous, active low) empties the car table and the stop queue by
// clearing their fill counts; no clearing pass is needed.
module elevator_call_dispatcher_unit #(
    parameter int MAX_CARS  = ecd_pkg::DEF_MAX_CARS,
    parameter int MAX_STOPS = ecd_pkg::DEF_MAX_STOPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_car_id,
    input  logic signed [7:0] i_lowest_floor,
    input  logic signed [7:0] i_highest_floor,
    input  logic signed [7:0] i_source_floor,
    input  logic signed [7:0] i_target_floor,
    input  logic [2:0]        i_door_state,
    input  logic signed [7:0] i_now_floor,
    input  logic signed [7:0] i_heading_floor,
    output logic              o_strobe,
    output logic [2:0]        o_answer,
    output logic [7:0]        o_chosen_car,
    output logic signed [7:0] o_stop_floor
);

    ecd_pkg::t_cmd cmd;
    ecd_pkg::t_sts sts;

    // sequencer
    ecd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // tables and result register
    ecd_dpath #(
        .MAX_CARS  (MAX_CARS),
        .MAX_STOPS (MAX_STOPS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_kind),
        .i_car_id        (i_car_id),
        .i_lowest_floor  (i_lowest_floor),
        .i_highest_floor (i_highest_floor),
        .i_source_floor  (i_source_floor),
        .i_target_floor  (i_target_floor),
        .i_door_state    (i_door_state),
        .i_now_floor     (i_now_floor),
        .i_heading_floor (i_heading_floor),
        .o_strobe        (o_strobe),
        .o_answer        (o_answer),
        .o_chosen_car    (o_chosen_car),
        .o_stop_floor    (o_stop_floor)
    );

endmodule

@@ tb/testbench.sv @@
// one result word as the dispatcher reports it
typedef struct {
    logic [2:0]        answer;
    logic [7:0]        car;
    logic signed [7:0] floor;
} t_dispatch_word;

// one entry of the car table
typedef struct {
    logic [7:0]        id;
    logic signed [7:0] low_fl;
    logic signed [7:0] high_fl;
    logic [2:0]        door;
    logic signed [7:0] now_fl;
    logic signed [7:0] dest_fl;
} t_car_slot;

// one queued stop
typedef struct {
    logic [7:0]        car;
    logic signed [7:0] floor;
} t_stop_slot;

class dispatch_scoreboard;
    localparam int CARS  = ecd_pkg::DEF_MAX_CARS;
    localparam int STOPS = ecd_pkg::DEF_MAX_STOPS;

    t_car_slot      cars [CARS];
    int             n_cars;
    t_stop_slot     stops [$];
    t_dispatch_word pending [$];
    int             errors;
    int             words_in;
    int             words_out;
    int             answer_seen [5];

    function new();
        n_cars    = 0;
        errors    = 0;
        words_in  = 0;
        words_out = 0;
        foreach (answer_seen[k]) answer_seen[k] = 0;
    endfunction

    function int car_index(logic [7:0] id);
        for (int k = 0; k < n_cars; k++)
            if (cars[k].id == id) return k;
        return -1;
    endfunction

    function bit serves(t_car_slot c, int a, int b);
        int lo;
        int hi;
        lo = c.low_fl;
        hi = c.high_fl;
        if (hi < lo) begin
            lo = c.high_fl;
            hi = c.low_fl;
        end
        return a >= lo && a <= hi && b >= lo && b <= hi;
    endfunction

    function void expect_word(logic [2:0] ans, logic [7:0] car, logic signed [7:0] fl);
        t_dispatch_word w;
        w.answer = ans;
        w.car    = car;
        w.floor  = fl;
        pending.push_back(w);
    endfunction

    // predict the effect of one accepted request word
    function void note_request(logic [1:0] kind, logic [7:0] id,
                               logic signed [7:0] lo, logic signed [7:0] hi,
                               logic signed [7:0] src, logic signed [7:0] dst,
                               logic [2:0] door, logic signed [7:0] now_fl,
                               logic signed [7:0] head_fl);
        int idx;
        int hit;
        words_in++;
        idx = car_index(id);
        case (kind)
            ecd_pkg::KIND_REG: begin
                if (n_cars >= CARS || idx >= 0) begin
                    expect_word(ecd_pkg::ANS_REJECT, id, 0);
                end else begin
                    cars[n_cars] = '{id, lo, hi, ecd_pkg::DOOR_CLOSED, lo, lo};
                    n_cars++;
                end
            end
            ecd_pkg::KIND_REMOVE: begin
                if (idx >= 0) begin
                    cars[idx] = cars[n_cars-1];
                    n_cars--;
                end
            end
            ecd_pkg::KIND_CALL: begin
                hit = -1;
                for (int k = 0; k < n_cars && hit < 0; k++)
                    if (serves(cars[k], src, dst)) hit = k;
                if (hit < 0) begin
                    expect_word(ecd_pkg::ANS_UNAVAIL, 0, 0);
                end else if (stops.size() + 2 > STOPS) begin
                    expect_word(ecd_pkg::ANS_QFULL, cars[hit].id, 0);
                end else begin
                    stops.push_back('{cars[hit].id, src});
                    stops.push_back('{cars[hit].id, dst});
                    expect_word(ecd_pkg::ANS_ASSIGNED, cars[hit].id, 0);
                end
            end
            default: begin
                if (idx >= 0) begin
                    cars[idx].door    = door;
                    cars[idx].now_fl  = now_fl;
                    cars[idx].dest_fl = head_fl;
                    if (door == ecd_pkg::DOOR_CLOSED || door == ecd_pkg::DOOR_OPENING ||
                        now_fl == head_fl) begin
                        hit = -1;
                        for (int k = 0; k < stops.size() && hit < 0; k++)
                            if (stops[k].car == id) hit = k;
                        if (hit >= 0) begin
                            expect_word(ecd_pkg::ANS_DISPATCH, id, stops[hit].floor);
                            stops.delete(hit);
                        end
                    end
                end
            end
        endcase
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_result(logic [2:0] ans, logic [7:0] car, logic signed [7:0] fl);
        t_dispatch_word w;
        words_out++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result answer=%0d car=%0d floor=%0d",
                     $time, ans, car, fl);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (ans <= ecd_pkg::ANS_QFULL) answer_seen[ans]++;
        if (ans !== w.answer) begin
            $display("%0t: answer expected %0d actual %0d", $time, w.answer, ans);
            errors++;
        end
        if (car !== w.car) begin
            $display("%0t: chosen_car expected %0d actual %0d", $time, w.car, car);
            errors++;
        end
        if (fl !== w.floor) begin
            $display("%0t: stop_floor expected %0d actual %0d", $time, w.floor, fl);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_kind;
    logic [7:0]        i_car_id;
    logic signed [7:0] i_lowest_floor;
    logic signed [7:0] i_highest_floor;
    logic signed [7:0] i_source_floor;
    logic signed [7:0] i_target_floor;
    logic [2:0]        i_door_state;
    logic signed [7:0] i_now_floor;
    logic signed [7:0] i_heading_floor;
    logic              o_strobe;
    logic [2:0]        o_answer;
    logic [7:0]        o_chosen_car;
    logic signed [7:0] o_stop_floor;

    dispatch_scoreboard board;
    int                burst_left;
    int                status_pct;

    elevator_call_dispatcher_unit DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #40000000;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    // result words are taken in the cycle they are shown
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_answer, o_chosen_car, o_stop_floor);
    end

    // issue one request word and wait for the edge that takes it
    task automatic issue(logic [1:0] kind, logic [7:0] id,
                         logic signed [7:0] lo, logic signed [7:0] hi,
                         logic signed [7:0] src, logic signed [7:0] dst,
                         logic [2:0] door, logic signed [7:0] now_fl,
                         logic signed [7:0] head_fl);
        int gap;
        start           <= 1'b1;
        i_kind          <= kind;
        i_car_id        <= id;
        i_lowest_floor  <= lo;
        i_highest_floor <= hi;
        i_source_floor  <= src;
        i_target_floor  <= dst;
        i_door_state    <= door;
        i_now_floor     <= now_fl;
        i_heading_floor <= head_fl;
        do @(posedge i_clk); while (busy);
        board.note_request(kind, id, lo, hi, src, dst, door, now_fl, head_fl);
        // bursts of back-to-back words separated by idle gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic signed [7:0] rand_floor();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'(int'($urandom_range(0, 14)) - 5);
    endfunction

    function automatic logic [7:0] rand_car();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 19));
    endfunction

    // one random request word, status share set by the current phase
    task automatic random_word();
        int roll;
        logic signed [7:0] f;
        roll = $urandom_range(0, 99);
        f = rand_floor();
        if (roll < 12)
            issue(ecd_pkg::KIND_REG, rand_car(), rand_floor(), rand_floor(), 0, 0, 0, 0, 0);
        else if (roll < 20)
            issue(ecd_pkg::KIND_REMOVE, rand_car(), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 100 - status_pct)
            issue(ecd_pkg::KIND_CALL, 8'($urandom), 8'($urandom), 8'($urandom),
                  rand_floor(), rand_floor(), 3'($urandom), 8'($urandom), 8'($urandom));
        else
            issue(ecd_pkg::KIND_STATUS, rand_car(), 8'($urandom), 8'($urandom), 0, 0,
                  3'($urandom_range(0, 7)), f,
                  ($urandom_range(0, 2) == 0) ? f : rand_floor());
    endtask

    initial begin
        board      = new();
        burst_left = 0;
        status_pct = 35;
        i_rst_n = 1'b0;
        start <= 1'b0;
        i_kind <= ecd_pkg::KIND_REG;
        i_car_id <= '0;
        i_lowest_floor <= '0;
        i_highest_floor <= '0;
        i_source_floor <= '0;
        i_target_floor <= '0;
        i_door_state <= '0;
        i_now_floor <= '0;
        i_heading_floor <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, reversed range, duplicate
        issue(ecd_pkg::KIND_CALL, 0, 0, 0, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_STATUS, 8'd7, 0, 0, 0, 0, ecd_pkg::DOOR_CLOSED, 0, 0);
        issue(ecd_pkg::KIND_REG, 8'd255, -128, 127, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_REG, 8'd0, 127, -128, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_REG, 8'd255, 0, 0, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_REMOVE, 8'd255, 0, 0, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_REMOVE, 8'd99, 0, 0, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_REG, 8'd5, 10, 2, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_CALL, 0, 0, 0, 3, 9, 0, 0, 0);
        issue(ecd_pkg::KIND_CALL, 0, 0, 0, -128, 127, 0, 0, 0);
        issue(ecd_pkg::KIND_CALL, 0, 0, 0, 127, -128, 0, 0, 0);
        // every door code once, with arrival only for codes 6 and 7
        for (int d = 0; d < 8; d++)
            issue(ecd_pkg::KIND_STATUS, (d % 2) ? 8'd5 : 8'd0, 0, 0, 0, 0, 3'(d), 4,
                  (d > 5) ? 8'sd4 : 8'sd6);
        issue(ecd_pkg::KIND_STATUS, 8'd5, 0, 0, 0, 0, 3'd4, 1, 2);
        issue(ecd_pkg::KIND_REMOVE, 8'd0, 0, 0, 0, 0, 0, 0, 0);
        issue(ecd_pkg::KIND_STATUS, 8'd0, 0, 0, 0, 0, ecd_pkg::DOOR_OPENING, 0, 0);

        // random phases alternate between filling and draining the stop queue
        for (int ph = 0; ph < 9; ph++) begin
            status_pct = (ph % 2) ? 55 : 8;
            for (int n = 0; n < 150; n++) random_word();
        end

        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("%0d request words, %0d result words (assigned %0d, unavailable %0d,",
                 board.words_in, board.words_out,
                 board.answer_seen[ecd_pkg::ANS_ASSIGNED],
                 board.answer_seen[ecd_pkg::ANS_UNAVAIL]);
        $display("  dispatched %0d, rejected %0d, queue full %0d)",
                 board.answer_seen[ecd_pkg::ANS_DISPATCH],
                 board.answer_seen[ecd_pkg::ANS_REJECT],
                 board.answer_seen[ecd_pkg::ANS_QFULL]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
